[design/qvlr_pkg.sv]
// ----------------------------------------------------------------------------
// qvlr_pkg
// Shared types and constants for the quadratic velocity loss rate block.
// ----------------------------------------------------------------------------
package qvlr_pkg;

  localparam int unsigned CellW  = 20;
  localparam int unsigned DepthW = 32;
  localparam int unsigned VelW   = 24;
  localparam int unsigned AccW   = 32;
  localparam int unsigned TsW    = 24;
  localparam int unsigned CfgW   = 32;
  localparam int unsigned InW    = 216;
  localparam int unsigned OutW   = 88;
  localparam int unsigned UserW  = 4;

  localparam int unsigned RadW    = 2 * VelW;
  localparam int unsigned RootW   = VelW;
  localparam int unsigned DvdW    = VelW + 16;
  localparam int unsigned SqrtLat = RootW;

  localparam logic CfgTimeStep = 1'b0;
  localparam logic CfgDryThr   = 1'b1;

  localparam logic [TsW-1:0]    TimeStepRst = 24'd65536;
  localparam logic [DepthW-1:0] DryThrRst   = 32'd17;

  localparam logic [AccW-1:0] AccMax = 32'h7fff_ffff;
  localparam logic [AccW-1:0] AccMin = 32'h8000_0000;

  typedef struct packed {
    logic [CellW-1:0] cell_idx;
    logic [AccW-1:0]  acc_u;
    logic [AccW-1:0]  acc_v;
    logic [VelW-1:0]  mag_u;
    logic [VelW-1:0]  mag_v;
    logic [VelW-1:0]  mag_fx;
    logic [VelW-1:0]  mag_fy;
    logic             neg_u;
    logic             neg_v;
    logic             neg_fx;
    logic             neg_fy;
    logic             dry;
  } fe_item_t;

  typedef struct packed {
    logic [CellW-1:0] cell_idx;
    logic [AccW-1:0]  rate_u;
    logic [AccW-1:0]  rate_v;
    logic             capped_u;
    logic             capped_v;
    logic             dry;
    logic             sat;
  } res_t;

endpackage

[design/qvlr_front.sv]
// ----------------------------------------------------------------------------
// qvlr_front
// Input register: splits signs from magnitudes and marks dry cells.
// ----------------------------------------------------------------------------
module qvlr_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [qvlr_pkg::DepthW-1:0]   thr_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [qvlr_pkg::CellW-1:0]    cell_i,
  input  logic [qvlr_pkg::DepthW-1:0]   depth_i,
  input  logic [qvlr_pkg::VelW-1:0]     vel_u_i,
  input  logic [qvlr_pkg::VelW-1:0]     vel_v_i,
  input  logic [qvlr_pkg::VelW-1:0]     loss_x_i,
  input  logic [qvlr_pkg::VelW-1:0]     loss_y_i,
  input  logic [qvlr_pkg::AccW-1:0]     rate_u_i,
  input  logic [qvlr_pkg::AccW-1:0]     rate_v_i,
  output logic                          item_valid_o,
  input  logic                          item_ready_i,
  output qvlr_pkg::fe_item_t            item_o
);

  logic               vld_q;
  qvlr_pkg::fe_item_t item_q, item_d;

  function automatic logic [qvlr_pkg::VelW-1:0] mag(input logic [qvlr_pkg::VelW-1:0] x);
    mag = x[qvlr_pkg::VelW-1] ? (~x + 1'b1) : x;
  endfunction

  assign in_ready_o = ~vld_q | item_ready_i;

  always_comb begin
    item_d.cell_idx = cell_i;
    item_d.acc_u  = rate_u_i;
    item_d.acc_v  = rate_v_i;
    item_d.mag_u  = mag(vel_u_i);
    item_d.mag_v  = mag(vel_v_i);
    item_d.mag_fx = mag(loss_x_i);
    item_d.mag_fy = mag(loss_y_i);
    item_d.neg_u  = vel_u_i[qvlr_pkg::VelW-1];
    item_d.neg_v  = vel_v_i[qvlr_pkg::VelW-1];
    item_d.neg_fx = loss_x_i[qvlr_pkg::VelW-1];
    item_d.neg_fy = loss_y_i[qvlr_pkg::VelW-1];
    item_d.dry    = (depth_i <= thr_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_d;
    end
  end

  assign item_valid_o = vld_q;
  assign item_o       = item_q;

endmodule

[design/qvlr_fifo.sv]
// ----------------------------------------------------------------------------
// qvlr_fifo
// Short queue between the front and the back.
// ----------------------------------------------------------------------------
module qvlr_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               ready_o,
  input  qvlr_pkg::fe_item_t wdata_i,
  input  logic               pop_i,
  output logic               valid_o,
  output qvlr_pkg::fe_item_t rdata_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  qvlr_pkg::fe_item_t mem_q [Depth];
  logic [PtrW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign ready_o = (cnt_q != CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i & ready_o;
  assign do_pop  = pop_i & valid_o;
  assign rdata_o = mem_q[rp_q];

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wp_d = (wp_q == PtrW'(Depth - 1)) ? '0 : wp_q + 1'b1;
    end
    if (do_pop) begin
      rp_d = (rp_q == PtrW'(Depth - 1)) ? '0 : rp_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

endmodule

[design/qvlr_sqrt.sv]
// ----------------------------------------------------------------------------
// qvlr_sqrt
// Pipelined integer square root, one root bit per stage, rounded down.
// ----------------------------------------------------------------------------
module qvlr_sqrt (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [qvlr_pkg::RadW-1:0]   rad_i,
  output logic [qvlr_pkg::RootW-1:0]  root_o
);

  localparam int unsigned Steps = qvlr_pkg::RootW;
  localparam int unsigned RemW  = qvlr_pkg::RootW + 2;
  localparam int unsigned XW    = RemW + 2;
  localparam int unsigned RW    = qvlr_pkg::RadW;

  logic [RW-1:0]                 rad_q  [Steps];
  logic [RemW-1:0]               rem_q  [Steps];
  logic [qvlr_pkg::RootW-1:0]    root_q [Steps];

  for (genvar i = 0; i < Steps; i++) begin : g_step
    logic [RW-1:0]              rad_in;
    logic [RemW-1:0]            rem_in;
    logic [qvlr_pkg::RootW-1:0] root_in;
    logic [XW-1:0]              x, trial;
    logic                       ge;

    if (i == 0) begin : g_first
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
    end

    assign x     = {rem_in, rad_in[RW-1 -: 2]};
    assign trial = {2'b00, root_in, 2'b01};
    assign ge    = (x >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[i]  <= {rad_in[RW-3:0], 2'b00};
        rem_q[i]  <= ge ? RemW'(x - trial) : x[RemW-1:0];
        root_q[i] <= {root_in[qvlr_pkg::RootW-2:0], ge};
      end
    end
  end

  assign root_o = root_q[Steps-1];

endmodule

[design/qvlr_div.sv]
// ----------------------------------------------------------------------------
// qvlr_div
// Pipelined radix-4 divider by the time step, padded to the root latency.
// ----------------------------------------------------------------------------
module qvlr_div (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [qvlr_pkg::TsW-1:0]   ts_i,
  input  logic [qvlr_pkg::DvdW-1:0]  dvd_i,
  output logic [qvlr_pkg::DvdW-1:0]  quo_o
);

  localparam int unsigned DW    = qvlr_pkg::DvdW;
  localparam int unsigned TW    = qvlr_pkg::TsW;
  localparam int unsigned Steps = DW / 2;
  localparam int unsigned Pad   = qvlr_pkg::SqrtLat - Steps;
  localparam int unsigned XW    = TW + 2;

  logic [DW-1:0] w_q   [Steps];
  logic [TW-1:0] r_q   [Steps];
  logic [DW-1:0] pad_q [Pad];
  logic [XW-1:0] t1, t2, t3;

  assign t1 = {2'b00, ts_i};
  assign t2 = {1'b0, ts_i, 1'b0};
  assign t3 = t1 + t2;

  for (genvar i = 0; i < Steps; i++) begin : g_step
    logic [DW-1:0] w_in;
    logic [TW-1:0] r_in;
    logic [XW-1:0] x, sub;
    logic [1:0]    dig;

    if (i == 0) begin : g_first
      assign w_in = dvd_i;
      assign r_in = '0;
    end else begin : g_next
      assign w_in = w_q[i-1];
      assign r_in = r_q[i-1];
    end

    assign x = {r_in, w_in[DW-1 -: 2]};

    always_comb begin
      if (x >= t3) begin
        dig = 2'd3;
        sub = t3;
      end else if (x >= t2) begin
        dig = 2'd2;
        sub = t2;
      end else if (x >= t1) begin
        dig = 2'd1;
        sub = t1;
      end else begin
        dig = 2'd0;
        sub = '0;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        w_q[i] <= {w_in[DW-3:0], dig};
        r_q[i] <= TW'(x - sub);
      end
    end
  end

  for (genvar j = 0; j < Pad; j++) begin : g_pad
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pad_q[j] <= (j == 0) ? w_q[Steps-1] : pad_q[(j == 0) ? 0 : j-1];
      end
    end
  end

  assign quo_o = pad_q[Pad-1];

endmodule

[design/qvlr_back.sv]
// ----------------------------------------------------------------------------
// qvlr_back
// Speed, loss rates, reversal cap and saturating accumulation; output stage.
// ----------------------------------------------------------------------------
module qvlr_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [qvlr_pkg::TsW-1:0]  ts_i,
  input  logic                      item_valid_i,
  output logic                      item_pop_o,
  input  qvlr_pkg::fe_item_t        item_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output qvlr_pkg::res_t            out_o
);

  localparam int unsigned Lat  = qvlr_pkg::SqrtLat;
  localparam int unsigned VW   = qvlr_pkg::VelW;
  localparam int unsigned PW   = 2 * VW;
  localparam int unsigned HW   = VW;
  localparam int unsigned MW   = 39;
  localparam int unsigned QW   = qvlr_pkg::DvdW;
  localparam int unsigned RW   = QW + 1;
  localparam int unsigned SW   = RW + 1;
  localparam int unsigned AW   = qvlr_pkg::AccW;

  typedef struct packed {
    qvlr_pkg::fe_item_t item;
    logic [PW-1:0]      pu;
    logic [PW-1:0]      pv;
  } side_t;

  logic en;

  // stage 1
  logic          s1_vld_q;
  side_t         s1_q;
  logic [PW-1:0] rad_s1;
  logic [PW-1:0] sq_u_q, sq_v_q;

  // delay line beside the root and divider pipes
  logic          dl_vld_q [Lat];
  side_t         dl_q     [Lat];
  logic [qvlr_pkg::RootW-1:0] speed;
  logic [QW-1:0] quo_u, quo_v;

  // stage 2
  logic               s2_vld_q;
  qvlr_pkg::fe_item_t s2_item_q;
  logic [QW-1:0]      s2_qu_q, s2_qv_q;
  logic [PW-1:0]      s2_uh_q, s2_ul_q, s2_vh_q, s2_vl_q;

  // stage 3
  logic               s3_vld_q;
  qvlr_pkg::fe_item_t s3_item_q;
  logic [QW-1:0]      s3_qu_q, s3_qv_q;
  logic [MW-1:0]      s3_mu_q, s3_mv_q;
  logic [PW+HW-1:0]   sum_u, sum_v;

  // stage 4
  logic               s4_vld_q;
  qvlr_pkg::fe_item_t s4_item_q;
  logic [QW-1:0]      s4_qu_q, s4_qv_q;
  logic [MW-1:0]      s4_mu_q, s4_mv_q;
  logic [43:0]        s4_tul_q, s4_tvl_q;
  logic [42:0]        s4_tuh_q, s4_tvh_q;

  // stage 5
  logic               s5_vld_q;
  qvlr_pkg::fe_item_t s5_item_q;
  logic [RW-1:0]      s5_ru_q, s5_rv_q, ru_d, rv_d;
  logic               s5_cu_q, s5_cv_q, cu_d, cv_d;

  // output
  logic               out_vld_q;
  qvlr_pkg::res_t     out_q, out_d;

  function automatic logic [RW-1:0] axis_rate(
    input logic [MW-1:0] mag,
    input logic [QW-1:0] quo,
    input logic [43:0]   tl,
    input logic [42:0]   th,
    input logic [VW-1:0] mv,
    input logic          vneg,
    input logic          cneg,
    output logic         capped
  );
    logic [63:0]   prod;
    logic [QW-1:0] m;
    logic          neg;
    prod   = {1'b0, th, 20'd0} + {20'd0, tl};
    capped = ~cneg && (mv != '0) && (prod > {24'd0, mv, 16'd0});
    m      = capped ? quo : QW'(mag);
    neg    = capped ? ~vneg : ~(vneg ^ cneg);
    axis_rate = neg ? (~{1'b0, m} + 1'b1) : {1'b0, m};
  endfunction

  function automatic logic [AW-1:0] sat_add(
    input logic [AW-1:0] acc,
    input logic [RW-1:0] rate,
    output logic         sat
  );
    logic [SW-1:0] s;
    s   = {{(SW-AW){acc[AW-1]}}, acc} + {rate[RW-1], rate};
    sat = (s[SW-1:AW-1] != '0) && (s[SW-1:AW-1] != '1);
    if (!sat) begin
      sat_add = s[AW-1:0];
    end else begin
      sat_add = s[SW-1] ? qvlr_pkg::AccMin : qvlr_pkg::AccMax;
    end
  endfunction

  assign en         = ~out_vld_q | out_ready_i;
  assign item_pop_o = en;
  assign rad_s1     = sq_u_q + sq_v_q;

  qvlr_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (rad_s1),
    .root_o (speed)
  );

  qvlr_div u_div_u (
    .clk_i (clk_i),
    .en_i  (en),
    .ts_i  (ts_i),
    .dvd_i ({s1_q.item.mag_u, 16'd0}),
    .quo_o (quo_u)
  );

  qvlr_div u_div_v (
    .clk_i (clk_i),
    .en_i  (en),
    .ts_i  (ts_i),
    .dvd_i ({s1_q.item.mag_v, 16'd0}),
    .quo_o (quo_v)
  );

  assign sum_u = {s2_uh_q, {HW{1'b0}}} + {{HW{1'b0}}, s2_ul_q};
  assign sum_v = {s2_vh_q, {HW{1'b0}}} + {{HW{1'b0}}, s2_vl_q};

  always_comb begin
    ru_d = axis_rate(s4_mu_q, s4_qu_q, s4_tul_q, s4_tuh_q, s4_item_q.mag_u,
                     s4_item_q.neg_u, s4_item_q.neg_fx, cu_d);
    rv_d = axis_rate(s4_mv_q, s4_qv_q, s4_tvl_q, s4_tvh_q, s4_item_q.mag_v,
                     s4_item_q.neg_v, s4_item_q.neg_fy, cv_d);
  end

  always_comb begin
    logic sat_u, sat_v;
    logic [AW-1:0] au, av;
    au = sat_add(s5_item_q.acc_u, s5_ru_q, sat_u);
    av = sat_add(s5_item_q.acc_v, s5_rv_q, sat_v);
    out_d.cell_idx = s5_item_q.cell_idx;
    out_d.dry  = s5_item_q.dry;
    if (s5_item_q.dry) begin
      out_d.rate_u   = s5_item_q.acc_u;
      out_d.rate_v   = s5_item_q.acc_v;
      out_d.capped_u = 1'b0;
      out_d.capped_v = 1'b0;
      out_d.sat      = 1'b0;
    end else begin
      out_d.rate_u   = au;
      out_d.rate_v   = av;
      out_d.capped_u = s5_cu_q;
      out_d.capped_v = s5_cv_q;
      out_d.sat      = sat_u | sat_v;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      s5_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      for (int k = 0; k < Lat; k++) begin
        dl_vld_q[k] <= 1'b0;
      end
    end else if (en) begin
      s1_vld_q    <= item_valid_i;
      dl_vld_q[0] <= s1_vld_q;
      for (int k = 1; k < Lat; k++) begin
        dl_vld_q[k] <= dl_vld_q[k-1];
      end
      s2_vld_q  <= dl_vld_q[Lat-1];
      s3_vld_q  <= s2_vld_q;
      s4_vld_q  <= s3_vld_q;
      s5_vld_q  <= s4_vld_q;
      out_vld_q <= s5_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q.item <= item_i;
      s1_q.pu   <= item_i.mag_u * item_i.mag_fx;
      s1_q.pv   <= item_i.mag_v * item_i.mag_fy;
      sq_u_q    <= item_i.mag_u * item_i.mag_u;
      sq_v_q    <= item_i.mag_v * item_i.mag_v;

      dl_q[0] <= s1_q;
      for (int k = 1; k < Lat; k++) begin
        dl_q[k] <= dl_q[k-1];
      end

      s2_item_q <= dl_q[Lat-1].item;
      s2_qu_q   <= quo_u;
      s2_qv_q   <= quo_v;
      s2_uh_q   <= dl_q[Lat-1].pu[PW-1:HW] * speed;
      s2_ul_q   <= dl_q[Lat-1].pu[HW-1:0] * speed;
      s2_vh_q   <= dl_q[Lat-1].pv[PW-1:HW] * speed;
      s2_vl_q   <= dl_q[Lat-1].pv[HW-1:0] * speed;

      s3_item_q <= s2_item_q;
      s3_qu_q   <= s2_qu_q;
      s3_qv_q   <= s2_qv_q;
      s3_mu_q   <= sum_u[PW+HW-1:33];
      s3_mv_q   <= sum_v[PW+HW-1:33];

      s4_item_q <= s3_item_q;
      s4_qu_q   <= s3_qu_q;
      s4_qv_q   <= s3_qv_q;
      s4_mu_q   <= s3_mu_q;
      s4_mv_q   <= s3_mv_q;
      s4_tul_q  <= s3_mu_q[19:0] * ts_i;
      s4_tuh_q  <= s3_mu_q[MW-1:20] * ts_i;
      s4_tvl_q  <= s3_mv_q[19:0] * ts_i;
      s4_tvh_q  <= s3_mv_q[MW-1:20] * ts_i;

      s5_item_q <= s4_item_q;
      s5_ru_q   <= ru_d;
      s5_rv_q   <= rv_d;
      s5_cu_q   <= cu_d;
      s5_cv_q   <= cv_d;

      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

endmodule

[design/quadratic_velocity_loss_rate.sv]
// ----------------------------------------------------------------------------
// quadratic_velocity_loss_rate
// Quadratic velocity loss rate for one shallow-water cell per item.
// ----------------------------------------------------------------------------
// The path from input accept to output valid is set by the 24-stage
// square root plus multiply, cap and accumulate stages.
// Throughput: one item per cycle; the back pipe stalls only on output stall.
// Reset: all valids clear, time_step loads 1.0 and dry_threshold loads 17.
module quadratic_velocity_loss_rate #(
  parameter int unsigned FifoDepth = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_addr_i,
  input  logic [qvlr_pkg::CfgW-1:0]     cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // cell_index, depth, vel_u, vel_v, loss_x, loss_y, rate_u_in, rate_v_in
  input  logic [qvlr_pkg::InW-1:0]      s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // cell_out, rate_u_out, rate_v_out
  output logic [qvlr_pkg::OutW-1:0]     m_axis_tdata,
  // capped_u, capped_v, dry_cell, saturated
  output logic [qvlr_pkg::UserW-1:0]    m_axis_tuser
);

  logic [qvlr_pkg::TsW-1:0]    ts_q;
  logic [qvlr_pkg::DepthW-1:0] thr_q;

  qvlr_pkg::fe_item_t fe_item, fq_item;
  logic               fe_valid, fq_ready, fq_valid, pop;
  qvlr_pkg::res_t     res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ts_q  <= qvlr_pkg::TimeStepRst;
      thr_q <= qvlr_pkg::DryThrRst;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        qvlr_pkg::CfgTimeStep: ts_q  <= cfg_wdata_i[qvlr_pkg::TsW-1:0];
        qvlr_pkg::CfgDryThr:   thr_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  qvlr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .thr_i        (thr_q),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .cell_i       (s_axis_tdata[19:0]),
    .depth_i      (s_axis_tdata[51:20]),
    .vel_u_i      (s_axis_tdata[75:52]),
    .vel_v_i      (s_axis_tdata[99:76]),
    .loss_x_i     (s_axis_tdata[123:100]),
    .loss_y_i     (s_axis_tdata[147:124]),
    .rate_u_i     (s_axis_tdata[179:148]),
    .rate_v_i     (s_axis_tdata[211:180]),
    .item_valid_o (fe_valid),
    .item_ready_i (fq_ready),
    .item_o       (fe_item)
  );

  qvlr_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fe_valid),
    .ready_o (fq_ready),
    .wdata_i (fe_item),
    .pop_i   (pop),
    .valid_o (fq_valid),
    .rdata_o (fq_item)
  );

  qvlr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ts_i         (ts_q),
    .item_valid_i (fq_valid),
    .item_pop_o   (pop),
    .item_i       (fq_item),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_o        (res)
  );

  assign m_axis_tdata = {4'd0, res.rate_v, res.rate_u, res.cell_idx};
  assign m_axis_tuser = {res.sat, res.dry, res.capped_v, res.capped_u};

endmodule

[design/qvlr_chk.sv]
// ----------------------------------------------------------------------------
// qvlr_chk
// Port-level checks for the quadratic velocity loss rate block.
// ----------------------------------------------------------------------------
module qvlr_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [qvlr_pkg::OutW-1:0]     m_axis_tdata,
  input logic [qvlr_pkg::UserW-1:0]    m_axis_tuser
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output item changed while stalled");

  a_dry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[2] |->
      !m_axis_tuser[0] && !m_axis_tuser[1] && !m_axis_tuser[3])
    else $error("dry cell flagged capped or saturated");

  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[3] |->
      m_axis_tdata[51:20] == qvlr_pkg::AccMax || m_axis_tdata[51:20] == qvlr_pkg::AccMin ||
      m_axis_tdata[83:52] == qvlr_pkg::AccMax || m_axis_tdata[83:52] == qvlr_pkg::AccMin)
    else $error("saturation flag without clamped rate");

  a_rst: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

bind quadratic_velocity_loss_rate qvlr_chk u_qvlr_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
